>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for concurrent properties on a clocked interface.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fpl2_pkg.sv
// ----------------------------------------------------------------------------
// fpl2_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpl2_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int VAL_W      = DATA_WIDTH - 1;
  localparam int FRAC_W     = 5;
  localparam int FRAC_MAX   = 30;
  localparam int OUT_W      = 36;
  localparam int IPART_W    = 6;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SQ_W       = DATA_WIDTH + 1;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);
  localparam logic [OUT_W-1:0]  ERR_CODE   = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic              REG_FRAC_BITS = 1'b0;

  typedef struct packed {
    logic load;
    logic shl;
    logic shr;
    logic mul;
    logic adj;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic lt_one;
    logic gt_two;
    logic fix_zero;
    logic last_round;
  } sts_t;

endpackage

>>> src/fpl2_datapath.sv
// ----------------------------------------------------------------------------
// fpl2_datapath
// Mantissa register, shifter, shared squaring multiplier, fraction bit
// shift register and result assembly.
// ----------------------------------------------------------------------------
module fpl2_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpl2_pkg::cmd_t                cmd,
  output fpl2_pkg::sts_t                sts,
  input  logic [fpl2_pkg::FRAC_W-1:0]   frac_bits,
  input  logic [fpl2_pkg::VAL_W-1:0]    value,
  output logic                          res_valid,
  output logic signed [fpl2_pkg::OUT_W-1:0] res_log
);
  import fpl2_pkg::*;

  logic [DATA_WIDTH-1:0]     a_r;
  logic signed [IPART_W-1:0] ipart_r;
  logic [FRAC_MAX-1:0]       bits_r;
  logic [FRAC_W-1:0]         cnt_r;
  logic [FRAC_W-1:0]         fix_r;
  logic                      err_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      valid_r;
  logic [OUT_W-1:0]          log_r;

  logic [FRAC_W-1:0]     fix_nxt;
  logic [DATA_WIDTH-1:0] one;
  logic [DATA_WIDTH-1:0] two;
  logic [PROD_W-1:0]     half;
  logic [PROD_W-1:0]     sq_full;
  logic [SQ_W-1:0]       sq;
  logic                  ge_two;
  logic [OUT_W-1:0]      ipart_ext;
  logic [OUT_W-1:0]      result;

  assign fix_nxt = (frac_bits > FRAC_W'(FRAC_MAX)) ? FRAC_W'(FRAC_MAX) : frac_bits;

  assign one     = DATA_WIDTH'(1) << fix_r;
  assign two     = one << 1;
  assign half    = (PROD_W'(1) << fix_r) >> 1;
  assign sq_full = (prod_r + half) >> fix_r;
  assign sq      = sq_full[SQ_W-1:0];
  assign ge_two  = sq >= {1'b0, two};

  assign ipart_ext = {{(OUT_W-IPART_W){ipart_r[IPART_W-1]}}, ipart_r};
  assign result    = (ipart_ext << fix_r) + {{(OUT_W-FRAC_MAX){1'b0}}, bits_r};

  assign sts.err        = err_r;
  assign sts.lt_one     = a_r < one;
  assign sts.gt_two     = a_r > two;
  assign sts.fix_zero   = (fix_r == '0);
  assign sts.last_round = ((cnt_r + FRAC_W'(1)) == fix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= {1'b0, value};
      ipart_r <= '0;
      bits_r  <= '0;
      cnt_r   <= '0;
      fix_r   <= fix_nxt;
      err_r   <= (value == '0);
    end
    if (cmd.shl) begin
      a_r     <= a_r << 1;
      ipart_r <= ipart_r - IPART_W'(1);
    end
    if (cmd.shr) begin
      a_r     <= a_r >> 1;
      ipart_r <= ipart_r + IPART_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(a_r) * PROD_W'(a_r);
    end
    if (cmd.adj) begin
      a_r    <= ge_two ? sq[SQ_W-1:1] : sq[DATA_WIDTH-1:0];
      bits_r <= {bits_r[FRAC_MAX-2:0], ge_two};
      cnt_r  <= cnt_r + FRAC_W'(1);
    end
    if (cmd.finish) begin
      log_r <= err_r ? ERR_CODE : result;
    end
  end

  assign res_valid = valid_r;
  assign res_log   = log_r;

endmodule

>>> src/fpl2_ctrl.sv
// ----------------------------------------------------------------------------
// fpl2_ctrl
// Sequencer: load, normalize one bit per cycle, then multiply/adjust per
// fraction bit, then assemble the result.
// ----------------------------------------------------------------------------
module fpl2_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  fpl2_pkg::sts_t sts,
  output fpl2_pkg::cmd_t cmd
);
  import fpl2_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_MUL,
    S_ADJ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.lt_one) begin
          cmd.shl = 1'b1;
        end else if (sts.gt_two) begin
          cmd.shr = 1'b1;
        end else if (sts.fix_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        cmd.adj   = 1'b1;
        state_nxt = sts.last_round ? S_DONE : S_MUL;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> src/fixed_point_log2_core.sv
// ----------------------------------------------------------------------------
// fixed_point_log2_core
// Base-2 logarithm of an unsigned fixed-point item by repeated squaring.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on
// out_log_value for one cycle with out_valid and cannot be held off. After
// start, the item runs S one-bit normalization shifts, where S is 0 to 30,
// then F square/adjust rounds, where F is frac_bits clamped to 30: the
// shift loop moves one bit per cycle, and every fraction bit needs one
// pass through the shared 32x32 multiplier plus a rounding/adjust step.
// A zero operand returns 0x800000000. busy drops in the cycle the result is
// shown, so the next item may start then. frac_bits sits at APB byte
// address 0 and is sampled when an item is taken.
// ----------------------------------------------------------------------------
module fixed_point_log2_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fpl2_pkg::VAL_W-1:0]           in_value,
  output logic                                 out_valid,
  output logic signed [fpl2_pkg::OUT_W-1:0]    out_log_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpl2_pkg::APB_AW-1:0]          paddr,
  input  logic [fpl2_pkg::APB_DW-1:0]          pwdata,
  output logic [fpl2_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);
  import fpl2_pkg::*;

  logic [FRAC_W-1:0] frac_bits_r;
  logic              reg_hit;
  cmd_t              cmd;
  sts_t              sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == REG_FRAC_BITS);
  assign prdata  = reg_hit ? {{(APB_DW-FRAC_W){1'b0}}, frac_bits_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_bits_r <= FRAC_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      frac_bits_r <= pwdata[FRAC_W-1:0];
    end
  end

  fpl2_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fpl2_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .frac_bits (frac_bits_r),
    .value     (in_value),
    .res_valid (out_valid),
    .res_log   (out_log_value)
  );

endmodule

>>> src/fpl2_checker.sv
// ----------------------------------------------------------------------------
// fpl2_checker
// Port-level checks of the start/busy/result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpl2_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  `ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy not set after start")
  `ASSERT_NXT(a_strobe_one, clk, rst_n, out_valid, !out_valid, "result strobe too long")
  `ASSERT_IMP(a_res_after_busy, clk, rst_n, out_valid, $past(busy) && !busy, "stray result")
  `ASSERT_IMP(a_busy_end_res, clk, rst_n, $fell(busy), out_valid, "item ended with no result")

endmodule

bind fixed_point_log2_core fpl2_checker u_fpl2_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
